FILE: rtl/core/mtd_pkg.sv
package mtd_pkg;

    localparam int unsigned COUNT_LIMIT_DEFAULT = 65535;

    localparam logic [3:0] ENC_MAC_ROMAN = 4'd0;
    localparam logic [3:0] ENC_WIN1252   = 4'd2;
    localparam logic [3:0] ENC_LAST_SB   = 4'd5;
    localparam logic [3:0] ENC_UTF8      = 4'd6;
    localparam logic [3:0] ENC_UNICODE   = 4'd7;
    localparam logic [3:0] ENC_UTF16BE   = 4'd8;
    localparam logic [3:0] ENC_LAST_16   = 4'd9;
    localparam logic [3:0] ENC_RESET     = ENC_UTF8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_UNSUPP    = 2'd2;

    function automatic logic [15:0] roman_hi(input logic [6:0] idx);
        logic [15:0] u;
        unique case (idx)
            7'd0: u = 16'h00C4; 7'd1: u = 16'h00C5; 7'd2: u = 16'h00C7; 7'd3: u = 16'h00C9;
            7'd4: u = 16'h00D1; 7'd5: u = 16'h00D6; 7'd6: u = 16'h00DC; 7'd7: u = 16'h00E1;
            7'd8: u = 16'h00E0; 7'd9: u = 16'h00E2; 7'd10: u = 16'h00E4; 7'd11: u = 16'h00E3;
            7'd12: u = 16'h00E5; 7'd13: u = 16'h00E7; 7'd14: u = 16'h00E9; 7'd15: u = 16'h00E8;
            7'd16: u = 16'h00EA; 7'd17: u = 16'h00EB; 7'd18: u = 16'h00ED; 7'd19: u = 16'h00EC;
            7'd20: u = 16'h00EE; 7'd21: u = 16'h00EF; 7'd22: u = 16'h00F1; 7'd23: u = 16'h00F3;
            7'd24: u = 16'h00F2; 7'd25: u = 16'h00F4; 7'd26: u = 16'h00F6; 7'd27: u = 16'h00F5;
            7'd28: u = 16'h00FA; 7'd29: u = 16'h00F9; 7'd30: u = 16'h00FB; 7'd31: u = 16'h00FC;
            7'd32: u = 16'h2020; 7'd33: u = 16'h00B0; 7'd34: u = 16'h00A2; 7'd35: u = 16'h00A3;
            7'd36: u = 16'h00A7; 7'd37: u = 16'h2022; 7'd38: u = 16'h00B6; 7'd39: u = 16'h00DF;
            7'd40: u = 16'h00AE; 7'd41: u = 16'h00A9; 7'd42: u = 16'h2122; 7'd43: u = 16'h00B4;
            7'd44: u = 16'h00A8; 7'd45: u = 16'h2260; 7'd46: u = 16'h00C6; 7'd47: u = 16'h00D8;
            7'd48: u = 16'h221E; 7'd49: u = 16'h00B1; 7'd50: u = 16'h2264; 7'd51: u = 16'h2265;
            7'd52: u = 16'h00A5; 7'd53: u = 16'h00B5; 7'd54: u = 16'h2202; 7'd55: u = 16'h2211;
            7'd56: u = 16'h220F; 7'd57: u = 16'h03C0; 7'd58: u = 16'h222B; 7'd59: u = 16'h00AA;
            7'd60: u = 16'h00BA; 7'd61: u = 16'h03A9; 7'd62: u = 16'h00E6; 7'd63: u = 16'h00F8;
            7'd64: u = 16'h00BF; 7'd65: u = 16'h00A1; 7'd66: u = 16'h00AC; 7'd67: u = 16'h221A;
            7'd68: u = 16'h0192; 7'd69: u = 16'h2248; 7'd70: u = 16'h2206; 7'd71: u = 16'h00AB;
            7'd72: u = 16'h00BB; 7'd73: u = 16'h2026; 7'd74: u = 16'h00A0; 7'd75: u = 16'h00C0;
            7'd76: u = 16'h00C3; 7'd77: u = 16'h00D5; 7'd78: u = 16'h0152; 7'd79: u = 16'h0153;
            7'd80: u = 16'h2013; 7'd81: u = 16'h2014; 7'd82: u = 16'h201C; 7'd83: u = 16'h201D;
            7'd84: u = 16'h2018; 7'd85: u = 16'h2019; 7'd86: u = 16'h00F7; 7'd87: u = 16'h25CA;
            7'd88: u = 16'h00FF; 7'd89: u = 16'h0178; 7'd90: u = 16'h2044; 7'd91: u = 16'h20AC;
            7'd92: u = 16'h2039; 7'd93: u = 16'h203A; 7'd94: u = 16'hFB01; 7'd95: u = 16'hFB02;
            7'd96: u = 16'h2021; 7'd97: u = 16'h00B7; 7'd98: u = 16'h201A; 7'd99: u = 16'h201E;
            7'd100: u = 16'h2030; 7'd101: u = 16'h00C2; 7'd102: u = 16'h00CA; 7'd103: u = 16'h00C1;
            7'd104: u = 16'h00CB; 7'd105: u = 16'h00C8; 7'd106: u = 16'h00CD; 7'd107: u = 16'h00CE;
            7'd108: u = 16'h00CF; 7'd109: u = 16'h00CC; 7'd110: u = 16'h00D3; 7'd111: u = 16'h00D4;
            7'd112: u = 16'hF8FF; 7'd113: u = 16'h00D2; 7'd114: u = 16'h00DA; 7'd115: u = 16'h00DB;
            7'd116: u = 16'h00D9; 7'd117: u = 16'h0131; 7'd118: u = 16'h02C6; 7'd119: u = 16'h02DC;
            7'd120: u = 16'h00AF; 7'd121: u = 16'h02D8; 7'd122: u = 16'h02D9; 7'd123: u = 16'h02DA;
            7'd124: u = 16'h00B8; 7'd125: u = 16'h02DD; 7'd126: u = 16'h02DB; 7'd127: u = 16'h02C7;
            default: u = 16'h0000;
        endcase
        return u;
    endfunction

    // zero marks an unassigned byte
    function automatic logic [15:0] cp1252_hi(input logic [4:0] idx);
        logic [15:0] u;
        unique case (idx)
            5'd0: u = 16'h20AC; 5'd2: u = 16'h201A; 5'd3: u = 16'h0192; 5'd4: u = 16'h201E;
            5'd5: u = 16'h2026; 5'd6: u = 16'h2020; 5'd7: u = 16'h2021; 5'd8: u = 16'h02C6;
            5'd9: u = 16'h2030; 5'd10: u = 16'h0160; 5'd11: u = 16'h2039; 5'd12: u = 16'h0152;
            5'd14: u = 16'h017D; 5'd17: u = 16'h2018; 5'd18: u = 16'h2019; 5'd19: u = 16'h201C;
            5'd20: u = 16'h201D; 5'd21: u = 16'h2022; 5'd22: u = 16'h2013; 5'd23: u = 16'h2014;
            5'd24: u = 16'h02DC; 5'd25: u = 16'h2122; 5'd26: u = 16'h0161; 5'd27: u = 16'h203A;
            5'd28: u = 16'h0153; 5'd30: u = 16'h017E; 5'd31: u = 16'h0178;
            default: u = 16'h0000;
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/multi_encoding_text_decoder_core.sv
// Text decoder: one raw byte per input item, UTF-16 code units out.
// Input channel: in_valid/in_stall with data_byte, byte_present, end_of_buffer.
// Output channel: out_valid/out_stall with code_unit, unit_valid, run_last,
// string_done, status, unit_count. One item yields zero, one or two results;
// two only for a UTF-8 surrogate pair, a closing item with no unit yields one
// result with unit_valid low.
// Config: cfg_we/cfg_data write the encoding register; write only while idle.
// An accepted item's first result is registered and shown in the next cycle.
// Throughput: one item per cycle when in_stall is low; the decode is a single
// registered pass. For a surrogate pair the second unit is held in a one-entry
// side register, and the input is stalled until it moves to the output.
// When the receiver stalls, the output register holds and input stall
// rises as soon as the output register is full and cannot drain.
// Reset clears all string state and output valid; encoding resets to UTF-8.
module multi_encoding_text_decoder_core #(
    parameter longint unsigned COUNT_LIMIT = mtd_pkg::COUNT_LIMIT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_buffer,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        run_last,
    output logic        string_done,
    output logic [1:0]  status,
    output logic [15:0] unit_count
);
    import mtd_pkg::*;

    localparam logic [15:0] CAP = (COUNT_LIMIT < 64'd65535) ? 16'(COUNT_LIMIT) : 16'hFFFF;

    typedef struct packed {
        logic [15:0] unit;
        logic        uvalid;
        logic        last;
        logic        done;
        logic [1:0]  st;
        logic [15:0] count;
    } res_t;

    logic [3:0]  enc_reg;
    logic [1:0]  cont_reg,  cont_next;
    logic [20:0] acc_reg,   acc_next;
    logic        seqf_reg,  seqf_next;
    logic [1:0]  pos_reg,   pos_next;
    logic [7:0]  held_reg,  held_next;
    logic        half_reg,  half_next;
    logic        be_reg,    be_next;
    logic        err_reg,   err_next;
    logic [15:0] cnt_reg,   cnt_next;

    logic  ov_reg;
    res_t  out_reg;
    logic  pend_reg;
    res_t  pend_res_reg;

    logic  out_free, accept;
    logic  e0, e1;
    logic [15:0] u0, u1;
    res_t  r0, r1;
    logic  nres_any;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = pend_reg || !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        logic [20:0] c, cm;
        logic [15:0] u;
        logic [15:0] c1;
        logic [1:0]  st;
        logic        bom, be;
        cont_next = cont_reg; acc_next = acc_reg; seqf_next = seqf_reg;
        pos_next = pos_reg; held_next = held_reg; half_next = half_reg;
        be_next = be_reg; err_next = err_reg; cnt_next = cnt_reg;
        e0 = 1'b0; e1 = 1'b0; u0 = '0; u1 = '0;
        c = '0; cm = '0; u = '0; st = ST_OK; bom = 1'b0; be = 1'b0;
        if (byte_present)
        begin
            if (pos_reg != 2'd3)
                pos_next = pos_reg + 2'd1;
            if (!err_reg)
            begin
                if (enc_reg <= ENC_LAST_SB)
                begin
                    u = {8'h00, data_byte};
                    if (data_byte[7])
                    begin
                        if (enc_reg == ENC_MAC_ROMAN)
                            u = roman_hi(data_byte[6:0]);
                        else if (enc_reg == ENC_WIN1252 && data_byte < 8'hA0
                                 && cp1252_hi(data_byte[4:0]) != 16'h0)
                            u = cp1252_hi(data_byte[4:0]);
                    end
                    e0 = 1'b1; u0 = u;
                end
                else if (enc_reg == ENC_UTF8)
                begin
                    if (cont_reg == 2'd0)
                    begin
                        seqf_next = 1'b0;
                        if (!data_byte[7])
                        begin
                            e0 = 1'b1; u0 = {8'h00, data_byte};
                        end
                        else if (data_byte[7:5] == 3'b110)
                        begin
                            acc_next = {16'h0, data_byte[4:0]}; cont_next = 2'd1;
                        end
                        else if (data_byte[7:4] == 4'b1110)
                        begin
                            acc_next = {17'h0, data_byte[3:0]}; cont_next = 2'd2;
                            seqf_next = (pos_reg == 2'd0) && (data_byte == 8'hEF);
                        end
                        else if (data_byte[7:3] == 5'b11110)
                        begin
                            acc_next = {18'h0, data_byte[2:0]}; cont_next = 2'd3;
                        end
                        else
                            err_next = 1'b1;
                    end
                    else if (data_byte[7:6] != 2'b10)
                        err_next = 1'b1;
                    else
                    begin
                        c = {acc_reg[14:0], data_byte[5:0]};
                        acc_next = c;
                        cont_next = cont_reg - 2'd1;
                        if (cont_reg == 2'd1)
                        begin
                            seqf_next = 1'b0;
                            if (seqf_reg && c == 21'h00FEFF)
                                bom = 1'b1;
                            else if (c >= 21'h010000)
                            begin
                                // values past the unicode range keep all high bits
                                cm = c - 21'h010000;
                                e0 = 1'b1; e1 = 1'b1;
                                u0 = 16'hD800 + {5'h0, cm[20:10]};
                                u1 = 16'hDC00 + {6'h0, cm[9:0]};
                            end
                            else
                            begin
                                e0 = 1'b1; u0 = c[15:0];
                            end
                        end
                    end
                end
                else if (enc_reg <= ENC_LAST_16)
                begin
                    if (!half_reg)
                    begin
                        held_next = data_byte; half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (enc_reg == ENC_UNICODE && pos_reg == 2'd1
                            && held_reg == 8'hFE && data_byte == 8'hFF)
                            be_next = 1'b1;
                        else if (enc_reg == ENC_UNICODE && pos_reg == 2'd1
                                 && held_reg == 8'hFF && data_byte == 8'hFE)
                            bom = 1'b1;
                        else
                        begin
                            be = (enc_reg == ENC_UTF16BE) || (enc_reg == ENC_UNICODE && be_reg);
                            e0 = 1'b1;
                            u0 = be ? {held_reg, data_byte} : {data_byte, held_reg};
                        end
                    end
                end
                else
                    err_next = 1'b1;
            end
        end
        c1 = (cnt_reg < CAP) ? cnt_reg + 16'd1 : cnt_reg;
        r0 = '{unit: u0, uvalid: e0, last: !e1, done: 1'b0, st: ST_OK, count: c1};
        r1 = '{unit: u1, uvalid: 1'b1, last: 1'b1, done: 1'b0, st: ST_OK,
               count: (c1 < CAP) ? c1 + 16'd1 : c1};
        if (e1) cnt_next = r1.count;
        else if (e0) cnt_next = c1;
        if (!e0) r0.count = cnt_reg;
        if (enc_reg > ENC_LAST_16) st = ST_UNSUPP;
        else if (err_next || cont_next != 2'd0) st = ST_MALFORMED;
        if (end_of_buffer)
        begin
            if (e1) begin r1.done = 1'b1; r1.st = st; end
            else begin r0.done = 1'b1; r0.st = st; end
            cont_next = '0; acc_next = '0; seqf_next = 1'b0; pos_next = '0;
            held_next = '0; half_next = 1'b0; be_next = 1'b0; err_next = 1'b0;
            cnt_next = '0;
        end
        nres_any = e0 || end_of_buffer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= ENC_RESET;
            cont_reg <= '0; acc_reg <= '0; seqf_reg <= 1'b0; pos_reg <= '0;
            held_reg <= '0; half_reg <= 1'b0; be_reg <= 1'b0; err_reg <= 1'b0;
            cnt_reg <= '0;
            ov_reg <= 1'b0; pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enc_reg <= cfg_data;
            if (accept)
            begin
                cont_reg <= cont_next; acc_reg <= acc_next; seqf_reg <= seqf_next;
                pos_reg <= pos_next; held_reg <= held_next; half_reg <= half_next;
                be_reg <= be_next; err_reg <= err_next; cnt_reg <= cnt_next;
            end
            if (out_free)
            begin
                if (pend_reg)
                begin
                    ov_reg <= 1'b1; pend_reg <= 1'b0;
                end
                else
                begin
                    ov_reg <= accept && nres_any;
                    pend_reg <= accept && e1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_reg)
                out_reg <= pend_res_reg;
            else if (accept)
            begin
                out_reg <= r0;
                pend_res_reg <= r1;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign code_unit   = out_reg.unit;
    assign unit_valid  = out_reg.uvalid;
    assign run_last    = out_reg.last;
    assign string_done = out_reg.done;
    assign status      = out_reg.st;
    assign unit_count  = out_reg.count;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(out_reg))
        else $error("output changed under stall");
    a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> in_stall)
        else $error("input accepted with pair half pending");
    a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> ov_reg && !out_reg.last)
        else $error("pending unit without first half shown");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_reg.done |-> out_reg.last)
        else $error("string_done without run_last");

endmodule
